// ----- hw/rtl/assert_macros.svh -----
// Assertion macros of the checker file of the jump-search table.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is applied.
`define JSST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also runs while reset is applied.
`define JSST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/jsst_pkg.sv -----
// Shared types and codes of the jump-search table.
// No dependencies; used by the interfaces, the top level and the checker.
package jsst_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    typedef logic                t_func;
    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FUNC_APPEND = 1'b0;
    localparam t_func FUNC_SEARCH = 1'b1;

    localparam t_status ST_APPENDED = 3'd0;
    localparam t_status ST_FULL     = 3'd1;
    localparam t_status ST_EXPRESS  = 3'd2;
    localparam t_status ST_BLOCK    = 3'd3;
    localparam t_status ST_TAIL     = 3'd4;
    localparam t_status ST_NOTFOUND = 3'd5;

endpackage

// ----- hw/rtl/jsst_if.sv -----
// Valid/ready channel interfaces of the jump-search table.
// Depends on jsst_pkg for the payload types.
interface jsst_in_if;
    import jsst_pkg::*;

    logic   valid;
    logic   ready;
    t_func  func;
    t_value value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface jsst_out_if;
    import jsst_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;

    modport source (output valid, output status, input ready);
    modport sink (input valid, input status, output ready);
endinterface

// ----- hw/rtl/jump_search_sorted_table_top.sv -----
// Jump-search table top level: value memory, entry counter and search sequencer.
// Depends on jsst_pkg and the channel interfaces in jsst_if.sv.
//
// An append transaction is written into the value memory when accepted; its status
// then moves to the output register in S_EMIT once that register is free. A search
// reads express entries first (each read is compared while the next one is already
// being fetched), then runs a block scan, a tail scan or both, each only if needed.
// A scan reads its entries in order and stops on a match; when a block scan misses,
// the tail scan that follows it starts after the block. The single read port of the
// value memory reads one entry per cycle. One transaction is worked on at a time;
// a new one is accepted while the previous status still waits in the output
// register. No clearing pass is needed after reset.
module jump_search_sorted_table_top #(
    parameter int MAX_ENTRIES = 256,
    parameter int STRIDE      = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    jsst_in_if.sink    i_in,
    jsst_out_if.source o_out
);
    import jsst_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = $clog2(MAX_ENTRIES + 2 * STRIDE + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);
    localparam logic [XW-1:0] STEP     = XW'(STRIDE);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_JUMP = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_value mem [MAX_ENTRIES];

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_end, n_end;
    logic          r_block, n_block;
    logic          r_rd_vld, n_rd_vld;
    t_value        r_key, n_key;
    t_value        r_rd_data;
    t_status       r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;

    logic          accept;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [XW-1:0] cnt_x, nxt_x, nxt2_x;
    logic          key_hit;

    assign accept  = i_in.valid && i_in.ready;
    assign cnt_x   = XW'(r_count);
    assign nxt_x   = XW'(r_cur) + STEP;
    assign nxt2_x  = nxt_x + STEP;
    assign key_hit = (r_rd_data == r_key);

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_end        = r_end;
        n_block      = r_block;
        n_rd_vld     = r_rd_vld;
        n_key        = r_key;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        rd_addr      = r_idx[AW-1:0];
        wr_en        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.func == FUNC_APPEND) begin
                        if (r_count == FULL_CNT) begin
                            n_res = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                            n_res   = ST_APPENDED;
                        end
                        n_state = S_EMIT;
                    end else begin
                        n_key = i_in.value;
                        n_cur = '0;
                        if (r_count == '0) begin
                            n_res   = ST_NOTFOUND;
                            n_state = S_EMIT;
                        end else if (STEP < cnt_x) begin
                            // Fetch the first express entry.
                            rd_en   = 1'b1;
                            rd_addr = STEP[AW-1:0];
                            n_state = S_JUMP;
                        end else begin
                            n_idx    = '0;
                            n_end    = r_count;
                            n_block  = 1'b0;
                            n_rd_vld = 1'b0;
                            n_state  = S_SCAN;
                        end
                    end
                end
            end
            S_JUMP: begin
                // r_rd_data holds the express entry at r_cur + STRIDE.
                if ($signed(r_rd_data) < $signed(r_key)) begin
                    n_cur = nxt_x[CW-1:0];
                    if (nxt2_x < cnt_x) begin
                        rd_en   = 1'b1;
                        rd_addr = nxt2_x[AW-1:0];
                    end else begin
                        n_idx    = nxt_x[CW-1:0];
                        n_end    = r_count;
                        n_block  = 1'b0;
                        n_rd_vld = 1'b0;
                        n_state  = S_SCAN;
                    end
                end else if (key_hit) begin
                    n_res   = ST_EXPRESS;
                    n_state = S_EMIT;
                end else begin
                    n_idx    = r_cur;
                    n_end    = nxt_x[CW-1:0];
                    n_block  = 1'b1;
                    n_rd_vld = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // One read issued per cycle; its data is compared in the next.
                if (r_rd_vld && key_hit) begin
                    n_res    = r_block ? ST_BLOCK : ST_TAIL;
                    n_rd_vld = 1'b0;
                    n_state  = S_EMIT;
                end else if (r_idx < r_end) begin
                    rd_en    = 1'b1;
                    rd_addr  = r_idx[AW-1:0];
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                end else if (r_rd_vld) begin
                    n_rd_vld = 1'b0;
                end else if (r_block) begin
                    // The block missed; the tail scan continues past the block,
                    // since the block entries are known not to match.
                    n_block = 1'b0;
                    n_end   = r_count;
                end else begin
                    n_res   = ST_NOTFOUND;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= i_in.value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_idx        <= n_idx;
        r_end        <= n_end;
        r_block      <= n_block;
        r_key        <= n_key;
        r_res        <= n_res;
        r_out_status <= n_out_status;
    end

endmodule

// ----- hw/rtl/jsst_checker.sv -----
// Port-level checker of the jump-search table and its bind to the top level.
// Depends on jsst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jsst_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input jsst_pkg::t_status        i_out_status
);
    import jsst_pkg::*;

    // A result that is stalled stays offered.
    `JSST_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "out valid dropped while stalled")

    // A stalled result keeps its status.
    `JSST_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_status), "status changed while stalled")

    // Only one transaction is in work at a time.
    `JSST_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "input accepted while busy")

    // Reset leaves no result offered.
    `JSST_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !i_out_valid, "out valid after reset")

endmodule

bind jump_search_sorted_table_top jsst_checker u_jsst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status)
);
